/* rtl/efi2e_pkg.sv */
// Shared types and constants for the UEFI to E820 memory map converter.
package efi2e_pkg;

    localparam int PAGE_SHIFT          = 12;
    localparam int MAX_ENTRIES_DEFAULT = 128;

    localparam logic [63:0] HOLE_LO = 64'h0000_0000_000A_0000;
    localparam logic [63:0] HOLE_HI = 64'h0000_0000_0010_0000;

    // input action codes
    localparam logic ACT_DESC = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // result kinds
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // E820 types
    localparam logic [2:0] MT_NONE = 3'd0;
    localparam logic [2:0] MT_RAM  = 3'd1;
    localparam logic [2:0] MT_RSVD = 3'd2;
    localparam logic [2:0] MT_ACPI = 3'd3;
    localparam logic [2:0] MT_NVS  = 3'd4;

    // UEFI memory types that matter here
    localparam logic [31:0] EFI_LDR_CODE       = 32'd1;
    localparam logic [31:0] EFI_LDR_DATA       = 32'd2;
    localparam logic [31:0] EFI_BOOT_SVC_CODE  = 32'd3;
    localparam logic [31:0] EFI_BOOT_SVC_DATA  = 32'd4;
    localparam logic [31:0] EFI_CONVENTIONAL   = 32'd7;
    localparam logic [31:0] EFI_ACPI_RECLAIM   = 32'd9;
    localparam logic [31:0] EFI_ACPI_NVS       = 32'd10;

    typedef struct packed {
        logic        action;
        logic [31:0] efi_type;
        logic [63:0] base_addr;
        logic [51:0] page_cnt;
    } desc_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] entry_addr;
        logic [63:0] entry_size;
        logic [2:0]  entry_type;
        logic [7:0]  entry_index;
        logic        overflowed;
        logic        last;
    } e820_t;

    // descriptor after type mapping and end computation
    typedef struct packed {
        logic        action;
        logic [2:0]  kind;
        logic [63:0] start;
        logic [63:0] size;
        logic [63:0] end_addr;
    } region_t;

    // results handed from the core to the output buffer
    typedef struct packed {
        logic [1:0] cnt;
        e820_t      r0;
        e820_t      r1;
    } push_t;

endpackage

/* rtl/efi_to_e820_memory_map.sv */
// A descriptor is registered in the input stage; when the core takes it, its result beats
// are loaded into the output buffer slots and the first one is presented from there.
// Throughput: one descriptor per cycle while each yields at most one beat and e820_stall
// is low; a descriptor or end-of-map item yielding two beats holds the input until the
// buffer drains its last beat, as the single result port drains one beat per cycle.
// Reset (rst_n low, asynchronous) empties both stages and clears pending entry, count and
// overflow flag.
module efi_to_e820_memory_map
    import efi2e_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  desc_valid,
    output logic  desc_stall,
    input  desc_t desc_data,
    output logic  e820_valid,
    input  logic  e820_stall,
    output e820_t e820_data
);

    logic    room;
    logic    take;
    region_t item;
    push_t   push;

    efi2e_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc_stall (desc_stall),
        .desc_data  (desc_data),
        .room       (room),
        .take       (take),
        .item       (item)
    );

    efi2e_core #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .push  (push)
    );

    efi2e_out_buf u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .push       (push),
        .room       (room),
        .e820_valid (e820_valid),
        .e820_stall (e820_stall),
        .e820_data  (e820_data)
    );

endmodule

/* rtl/efi2e_in_stage.sv */
// Input register: captures a descriptor, maps its type and precomputes its end.
module efi2e_in_stage
    import efi2e_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    desc_valid,
    output logic    desc_stall,
    input  desc_t   desc_data,
    input  logic    room,
    output logic    take,
    output region_t item
);

    logic       vld_reg;
    logic       vld_next;
    region_t    item_reg;
    logic       accept;
    logic [2:0] kind_map;
    logic [63:0] size_in;

    always_comb
    begin
        case (desc_data.efi_type) inside
            EFI_LDR_CODE, EFI_LDR_DATA, EFI_BOOT_SVC_CODE,
            EFI_BOOT_SVC_DATA, EFI_CONVENTIONAL:
                kind_map = MT_RAM;
            EFI_ACPI_RECLAIM:
                kind_map = MT_ACPI;
            EFI_ACPI_NVS:
                kind_map = MT_NVS;
            default:
                kind_map = MT_RSVD;
        endcase
    end

    assign size_in    = 64'(desc_data.page_cnt) << PAGE_SHIFT;
    assign take       = vld_reg && room;
    assign desc_stall = vld_reg && !take;
    assign accept     = desc_valid && !desc_stall;
    assign vld_next   = accept || (vld_reg && !take);
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action   <= desc_data.action;
            item_reg.kind     <= kind_map;
            item_reg.start    <= desc_data.base_addr;
            item_reg.size     <= size_in;
            item_reg.end_addr <= desc_data.base_addr + size_in;
        end
    end

endmodule

/* rtl/efi2e_core.sv */
// Pending-entry state, hole clipping, merging and result generation.
module efi2e_core
    import efi2e_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  region_t item,
    output push_t   push
);

    localparam logic [7:0] MAX_CNT = 8'(MAX_ENTRIES);

    typedef struct packed {
        logic [63:0] addr;
        logic [63:0] size;
        logic [63:0] end_addr;
        logic [2:0]  kind;
        logic        valid;
        logic [7:0]  used;
        logic        ovf;
    } pend_t;

    typedef struct packed {
        pend_t st;
        logic  emit;
        e820_t ent;
    } add_t;

    pend_t state_reg;
    pend_t state_next;
    add_t  add_a;
    add_t  add_b;
    e820_t flush_ent;
    e820_t summary_ent;
    logic  is_ram;
    logic  in_hole;
    logic  do_a;
    logic  do_b;
    logic [63:0] a_start;
    logic [63:0] a_size;
    logic [63:0] a_end;

    function automatic e820_t make_entry(pend_t st);
        e820_t e;
        e.kind        = KIND_ENTRY;
        e.entry_addr  = st.addr;
        e.entry_size  = st.size;
        e.entry_type  = st.kind;
        e.entry_index = st.used - 8'd1;
        e.overflowed  = st.ovf;
        e.last        = 1'b0;
        return e;
    endfunction

    // new size on merge: end - base, equal to old size + region size mod 2^64
    function automatic add_t add_region(pend_t st, logic [63:0] s, logic [63:0] sz,
                                        logic [63:0] e, logic [2:0] k);
        add_t r;
        r.st   = st;
        r.emit = 1'b0;
        r.ent  = make_entry(st);
        if (st.used >= MAX_CNT)
        begin
            r.st.ovf = 1'b1;
        end
        else if (st.valid && st.end_addr == s && st.kind == k)
        begin
            r.st.size     = e - st.addr;
            r.st.end_addr = e;
        end
        else
        begin
            r.emit        = st.valid;
            r.st.addr     = s;
            r.st.size     = sz;
            r.st.end_addr = e;
            r.st.kind     = k;
            r.st.valid    = 1'b1;
            r.st.used     = st.used + 8'd1;
        end
        return r;
    endfunction

    always_comb
    begin
        is_ram  = (item.kind == MT_RAM);
        in_hole = is_ram && (item.start < HOLE_HI) && (item.end_addr > HOLE_LO);

        // region A: whole region, or the part below 640K; region B: part above 1MB
        do_a    = !in_hole || (item.start < HOLE_LO);
        do_b    = in_hole && (item.end_addr > HOLE_HI);
        a_start = item.start;
        a_size  = in_hole ? (HOLE_LO - item.start) : item.size;
        a_end   = in_hole ? HOLE_LO : item.end_addr;

        add_a = add_region(state_reg, a_start, a_size, a_end, item.kind);
        if (!do_a)
        begin
            add_a.st   = state_reg;
            add_a.emit = 1'b0;
        end
        add_b = add_region(add_a.st, HOLE_HI, item.end_addr - HOLE_HI, item.end_addr,
                           MT_RAM);
        if (!do_b)
        begin
            add_b.st   = add_a.st;
            add_b.emit = 1'b0;
        end

        flush_ent = make_entry(state_reg);

        summary_ent.kind        = KIND_SUMMARY;
        summary_ent.entry_addr  = '0;
        summary_ent.entry_size  = '0;
        summary_ent.entry_type  = MT_NONE;
        summary_ent.entry_index = state_reg.used;
        summary_ent.overflowed  = state_reg.ovf;
        summary_ent.last        = 1'b1;

        push = '0;
        if (item.action == ACT_END)
        begin
            state_next = '0;
            if (state_reg.valid)
            begin
                push.cnt = 2'd2;
                push.r0  = flush_ent;
                push.r1  = summary_ent;
            end
            else
            begin
                push.cnt = 2'd1;
                push.r0  = summary_ent;
            end
        end
        else
        begin
            state_next = add_b.st;
            push.cnt   = 2'(add_a.emit) + 2'(add_b.emit);
            push.r0    = add_a.emit ? add_a.ent : add_b.ent;
            push.r1    = add_b.ent;
            if (add_a.emit && add_b.emit)
            begin
                push.r1.last = 1'b1;
            end
            else
            begin
                push.r0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (take)
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/efi2e_out_buf.sv */
// Two-slot result buffer; a descriptor may produce two beats.
module efi2e_out_buf
    import efi2e_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  take,
    input  push_t push,
    output logic  room,
    output logic  e820_valid,
    input  logic  e820_stall,
    output e820_t e820_data
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    e820_t      slot0_reg;
    e820_t      slot1_reg;
    logic       pop;
    logic       load;

    assign e820_valid = (cnt_reg != 2'd0);
    assign e820_data  = slot0_reg;
    assign pop        = e820_valid && !e820_stall;
    // core may write only when the buffer is empty or drains its last beat this cycle
    assign room       = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !e820_stall);
    assign load       = take && (push.cnt != 2'd0);

    always_comb
    begin
        if (load)
        begin
            cnt_next = push.cnt;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= push.r0;
            slot1_reg <= push.r1;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

/* rtl/efi2e_checker.sv */
// Port-level assertions for the converter, bound to the top level.
module efi2e_checker
    import efi2e_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  desc_valid,
    input logic  desc_stall,
    input desc_t desc_data,
    input logic  e820_valid,
    input logic  e820_stall,
    input e820_t e820_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        e820_valid && e820_stall |=> e820_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        e820_valid && e820_stall |=> $stable(e820_data))
        else $error("result beat changed while stalled");

    a_entry_type: assert property (@(posedge clk) disable iff (!rst_n)
        e820_valid && e820_data.kind == KIND_ENTRY |->
            e820_data.entry_type == MT_RAM || e820_data.entry_type == MT_RSVD ||
            e820_data.entry_type == MT_ACPI || e820_data.entry_type == MT_NVS)
        else $error("entry beat with bad type");

    a_summary: assert property (@(posedge clk) disable iff (!rst_n)
        e820_valid && e820_data.kind == KIND_SUMMARY |->
            e820_data.last && e820_data.entry_type == MT_NONE &&
            e820_data.entry_addr == 64'd0 && e820_data.entry_size == 64'd0)
        else $error("malformed summary beat");

endmodule

bind efi_to_e820_memory_map efi2e_checker u_chk (.*);
